// ----- src/taa_pkg.sv -----
`timescale 1ns / 1ps

package taa_pkg;

   localparam int TAPS_DEFAULT     = 8;
   localparam int CHANNELS_DEFAULT = 6;
   localparam int BURST_LENGTH     = 20;
   localparam int DISCARD_COUNT    = 10;

   localparam int SAMPLE_W = 16;
   localparam int CHAN_W   = 3;
   localparam int AMP_W    = 16;
   localparam int DIVR_W   = 16;
   localparam int COEF_W   = 10;
   localparam int ACC_W    = 32;
   localparam int QUO_W    = 22;
   localparam int BIT_W    = 4;
   localparam int CNT_W    = 5;
   localparam int TAB_W    = 4;
   localparam int TAB_LEN  = 10;

   // x / 100 == (x * DIV100_MAGIC) >> DIV100_SHIFT for any 32-bit x
   localparam logic [31:0] DIV100_MAGIC = 32'h51EB851F;
   localparam int          DIV100_SHIFT = 37;

   // tone table already scaled by 5
   localparam logic signed [COEF_W-1:0] COS5 [TAB_LEN] = '{
      10'sd500, 10'sd405, 10'sd155, -10'sd155, -10'sd405,
      -10'sd500, -10'sd405, -10'sd155, 10'sd155, 10'sd405
   };
   localparam logic signed [COEF_W-1:0] SIN5 [TAB_LEN] = '{
      10'sd0, 10'sd295, 10'sd475, 10'sd475, 10'sd295,
      10'sd0, -10'sd295, -10'sd475, -10'sd475, -10'sd295
   };

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCUM,
      OP_QC,
      OP_QS,
      OP_SQC,
      OP_SQS,
      OP_RAD,
      OP_ROOT,
      OP_AMP,
      OP_WIN,
      OP_DIV,
      OP_LOAD
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [TAB_W-1:0]   tab_idx;
      logic [BIT_W-1:0]   bit_idx;
   } cmd_type;

   typedef struct packed {
      logic sat;
   } stat_type;

endpackage

// ----- src/taa_ram.sv -----
`timescale 1ns / 1ps

module taa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 48,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/taa_ctrl.sv -----
`timescale 1ns / 1ps

module taa_ctrl #(
   parameter int TAPS = taa_pkg::TAPS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  taa_pkg::stat_type  stat,
   output taa_pkg::cmd_type   cmd
);

   localparam int SUM_W  = taa_pkg::AMP_W + $clog2(TAPS);
   localparam int STEP_W = $clog2(SUM_W);

   typedef enum logic [3:0] {
      S_IDLE,
      S_QC,
      S_QS,
      S_SQC,
      S_SQS,
      S_RAD,
      S_ROOT,
      S_AMP,
      S_WIN,
      S_DIV,
      S_OUT
   } state_type;

   state_type                    state_ff, state_in;
   logic [taa_pkg::CNT_W-1:0]    sample_cnt_ff, sample_cnt_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [taa_pkg::CNT_W-1:0]    next_cnt;
   logic                         accept;
   logic                         last;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign next_cnt   = sample_cnt_ff + taa_pkg::CNT_W'(1);
   assign last       = (next_cnt == taa_pkg::CNT_W'(taa_pkg::BURST_LENGTH));

   always_comb begin
      state_in      = state_ff;
      sample_cnt_in = sample_cnt_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      cmd.op        = taa_pkg::OP_NONE;
      cmd.tab_idx   = last ? '0 :
                      taa_pkg::TAB_W'(next_cnt - taa_pkg::CNT_W'(taa_pkg::DISCARD_COUNT));
      cmd.bit_idx   = step_ff[taa_pkg::BIT_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (next_cnt > taa_pkg::CNT_W'(taa_pkg::DISCARD_COUNT)) begin
                  cmd.op = taa_pkg::OP_ACCUM;
               end
               if (last) begin
                  sample_cnt_in = '0;
                  state_in      = S_QC;
               end else begin
                  sample_cnt_in = next_cnt;
               end
            end
         end
         S_QC: begin
            cmd.op   = taa_pkg::OP_QC;
            state_in = S_QS;
         end
         S_QS: begin
            cmd.op   = taa_pkg::OP_QS;
            state_in = S_SQC;
         end
         S_SQC: begin
            cmd.op   = taa_pkg::OP_SQC;
            state_in = S_SQS;
         end
         S_SQS: begin
            cmd.op   = taa_pkg::OP_SQS;
            state_in = S_RAD;
         end
         S_RAD: begin
            cmd.op   = taa_pkg::OP_RAD;
            step_in  = STEP_W'(taa_pkg::AMP_W - 1);
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (stat.sat) begin
               state_in = S_AMP;
            end else begin
               cmd.op = taa_pkg::OP_ROOT;
               if (step_ff == '0) begin
                  state_in = S_AMP;
               end else begin
                  step_in = step_ff - STEP_W'(1);
               end
            end
         end
         S_AMP: begin
            cmd.op   = taa_pkg::OP_AMP;
            state_in = S_WIN;
         end
         S_WIN: begin
            cmd.op   = taa_pkg::OP_WIN;
            step_in  = STEP_W'(SUM_W - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = taa_pkg::OP_DIV;
            if (step_ff == '0) begin
               state_in = S_OUT;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op       = taa_pkg::OP_LOAD;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         sample_cnt_ff <= '0;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sample_cnt_ff <= sample_cnt_in;
         step_ff       <= step_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule

// ----- src/taa_datapath.sv -----
`timescale 1ns / 1ps

module taa_datapath #(
   parameter int TAPS     = taa_pkg::TAPS_DEFAULT,
   parameter int CHANNELS = taa_pkg::CHANNELS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  taa_pkg::cmd_type               cmd,
   output taa_pkg::stat_type              stat,
   input  logic [taa_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic [taa_pkg::CHAN_W-1:0]     req_channel,
   input  logic                           csr_wr_en,
   input  logic [taa_pkg::DIVR_W-1:0]     csr_wr_data,
   output logic [taa_pkg::CHAN_W-1:0]     rsp_channel,
   output logic [taa_pkg::AMP_W-1:0]      rsp_amplitude,
   output logic [taa_pkg::AMP_W-1:0]      rsp_filtered
);

   localparam int POS_W    = $clog2(TAPS);
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DEPTH    = CHANNELS * TAPS;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int SUM_W    = taa_pkg::AMP_W + $clog2(TAPS);
   localparam int TAP_W    = $clog2(TAPS + 1);
   localparam int DEN_W    = taa_pkg::DIVR_W + TAP_W;
   localparam int MAG_W    = 2 * taa_pkg::QUO_W + 1;
   localparam int RAD_W    = MAG_W + 5;
   localparam int PROD_W   = taa_pkg::SAMPLE_W + taa_pkg::COEF_W + 2;
   localparam int ACC_W    = taa_pkg::ACC_W;
   localparam int AMP_W    = taa_pkg::AMP_W;

   logic signed [ACC_W-1:0]        acc_c_ff, acc_c_in, acc_s_ff, acc_s_in;
   logic [taa_pkg::DIVR_W-1:0]     divisor_ff, divisor_in;
   logic [SUM_W-1:0]               win_sum_ff [CHANNELS];
   logic [SUM_W-1:0]               win_sum_in [CHANNELS];
   logic [POS_W-1:0]               win_pos_ff [CHANNELS];
   logic [POS_W-1:0]               win_pos_in [CHANNELS];
   logic [DEPTH-1:0]               valid_ff, valid_in;

   logic [taa_pkg::CHAN_W-1:0]     chan_ff, chan_in;
   logic [taa_pkg::QUO_W-1:0]      qc_ff, qc_in, qs_ff, qs_in;
   logic [MAG_W-1:0]               mag_ff, mag_in;
   logic [31:0]                    rad_ff, rad_in;
   logic                           sat_ff, sat_in;
   logic [AMP_W-1:0]               root_ff, root_in, amp_ff, amp_in;
   logic [DEN_W-1:0]               rem_ff, rem_in, den_ff, den_in;
   logic [SUM_W-1:0]               quo_ff, quo_in;
   logic [taa_pkg::CHAN_W-1:0]     rsp_chan_ff, rsp_chan_in;
   logic [AMP_W-1:0]               rsp_amp_ff, rsp_amp_in, rsp_filt_ff, rsp_filt_in;

   logic signed [taa_pkg::SAMPLE_W+1:0] samp_sgn;
   logic signed [PROD_W-1:0]       prod_c, prod_s;
   logic [ACC_W-1:0]               abs_c, abs_s;
   logic [31:0]                    mul_a, mul_b;
   logic [63:0]                    mul_p;
   logic [AMP_W-1:0]               trial;
   logic [RAD_W-1:0]               mag_ext, rad_full;
   logic [CH_IDX_W-1:0]            ch_idx;
   logic                           ch_ok;
   logic [POS_W-1:0]               pos;
   logic [ADDR_W-1:0]              win_addr;
   logic [AMP_W-1:0]               old_amp, ram_rd;
   logic [SUM_W-1:0]               new_sum;
   logic [taa_pkg::DIVR_W-1:0]     div_eff;
   logic [DEN_W:0]                 rem_sh;
   logic                           rem_ge;
   logic                           ram_we;

   assign samp_sgn = {2'b00, req_sample};
   assign prod_c   = samp_sgn * taa_pkg::COS5[cmd.tab_idx];
   assign prod_s   = samp_sgn * taa_pkg::SIN5[cmd.tab_idx];
   assign abs_c    = acc_c_ff[ACC_W-1] ? ACC_W'(-acc_c_ff) : ACC_W'(acc_c_ff);
   assign abs_s    = acc_s_ff[ACC_W-1] ? ACC_W'(-acc_s_ff) : ACC_W'(acc_s_ff);
   assign trial    = root_ff | (AMP_W'(1) << cmd.bit_idx);
   assign div_eff  = (divisor_ff == '0) ? taa_pkg::DIVR_W'(1) : divisor_ff;
   assign mag_ext  = RAD_W'(mag_ff);
   assign rad_full = (mag_ext << 4) + (mag_ext << 3) + mag_ext;

   assign ch_idx   = CH_IDX_W'(chan_ff);
   assign ch_ok    = ({1'b0, chan_ff} < CHANNELS);
   assign pos      = win_pos_ff[ch_idx];
   assign win_addr = ADDR_W'(ch_idx * TAPS + pos);
   assign old_amp  = valid_ff[win_addr] ? ram_rd : '0;
   assign new_sum  = win_sum_ff[ch_idx] - SUM_W'(old_amp) + SUM_W'(amp_ff);
   assign ram_we   = (cmd.op == taa_pkg::OP_WIN) && ch_ok;
   assign rem_sh   = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_ge   = (rem_sh >= {1'b0, den_ff});

   always_comb begin
      unique case (cmd.op)
         taa_pkg::OP_QC: begin
            mul_a = abs_c;
            mul_b = taa_pkg::DIV100_MAGIC;
         end
         taa_pkg::OP_QS: begin
            mul_a = abs_s;
            mul_b = taa_pkg::DIV100_MAGIC;
         end
         taa_pkg::OP_SQC: begin
            mul_a = 32'(qc_ff);
            mul_b = 32'(qc_ff);
         end
         taa_pkg::OP_SQS: begin
            mul_a = 32'(qs_ff);
            mul_b = 32'(qs_ff);
         end
         taa_pkg::OP_ROOT: begin
            mul_a = 32'(trial);
            mul_b = 32'(trial);
         end
         taa_pkg::OP_WIN: begin
            mul_a = 32'(div_eff);
            mul_b = 32'(TAPS);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = 64'(mul_a) * 64'(mul_b);

   taa_ram #(
      .WIDTH (AMP_W),
      .DEPTH (DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (win_addr),
      .wr_data (amp_ff),
      .rd_addr (win_addr),
      .rd_data (ram_rd)
   );

   always_comb begin
      acc_c_in    = acc_c_ff;
      acc_s_in    = acc_s_ff;
      divisor_in  = csr_wr_en ? csr_wr_data : divisor_ff;
      win_sum_in  = win_sum_ff;
      win_pos_in  = win_pos_ff;
      valid_in    = valid_ff;
      chan_in     = chan_ff;
      qc_in       = qc_ff;
      qs_in       = qs_ff;
      mag_in      = mag_ff;
      rad_in      = rad_ff;
      sat_in      = sat_ff;
      root_in     = root_ff;
      amp_in      = amp_ff;
      rem_in      = rem_ff;
      den_in      = den_ff;
      quo_in      = quo_ff;
      rsp_chan_in = rsp_chan_ff;
      rsp_amp_in  = rsp_amp_ff;
      rsp_filt_in = rsp_filt_ff;
      unique case (cmd.op)
         taa_pkg::OP_ACCUM: begin
            acc_c_in = acc_c_ff + ACC_W'(prod_c);
            acc_s_in = acc_s_ff + ACC_W'(prod_s);
            chan_in  = req_channel;
         end
         taa_pkg::OP_QC: begin
            qc_in = mul_p[taa_pkg::DIV100_SHIFT +: taa_pkg::QUO_W];
         end
         taa_pkg::OP_QS: begin
            qs_in    = mul_p[taa_pkg::DIV100_SHIFT +: taa_pkg::QUO_W];
            acc_c_in = '0;
            acc_s_in = '0;
         end
         taa_pkg::OP_SQC: begin
            mag_in = MAG_W'(mul_p);
         end
         taa_pkg::OP_SQS: begin
            mag_in = mag_ff + MAG_W'(mul_p);
         end
         taa_pkg::OP_RAD: begin
            rad_in  = rad_full[31:0];
            sat_in  = |rad_full[RAD_W-1:32];
            root_in = '0;
         end
         taa_pkg::OP_ROOT: begin
            if (mul_p <= 64'(rad_ff)) begin
               root_in = trial;
            end
         end
         taa_pkg::OP_AMP: begin
            amp_in = sat_ff ? '1 : root_ff;
         end
         taa_pkg::OP_WIN: begin
            rem_in = '0;
            den_in = DEN_W'(mul_p);
            quo_in = ch_ok ? new_sum : '0;
            if (ch_ok) begin
               win_sum_in[ch_idx] = new_sum;
               win_pos_in[ch_idx] = (pos == POS_W'(TAPS - 1)) ? '0 : pos + POS_W'(1);
               valid_in[win_addr] = 1'b1;
            end
         end
         taa_pkg::OP_DIV: begin
            rem_in = rem_ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : DEN_W'(rem_sh);
            quo_in = {quo_ff[SUM_W-2:0], rem_ge};
         end
         taa_pkg::OP_LOAD: begin
            rsp_chan_in = chan_ff;
            rsp_amp_in  = amp_ff;
            rsp_filt_in = quo_ff[AMP_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_c_ff   <= '0;
         acc_s_ff   <= '0;
         divisor_ff <= taa_pkg::DIVR_W'(1);
         valid_ff   <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            win_sum_ff[i] <= '0;
            win_pos_ff[i] <= '0;
         end
      end else begin
         acc_c_ff   <= acc_c_in;
         acc_s_ff   <= acc_s_in;
         divisor_ff <= divisor_in;
         valid_ff   <= valid_in;
         win_sum_ff <= win_sum_in;
         win_pos_ff <= win_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_ff     <= chan_in;
      qc_ff       <= qc_in;
      qs_ff       <= qs_in;
      mag_ff      <= mag_in;
      rad_ff      <= rad_in;
      sat_ff      <= sat_in;
      root_ff     <= root_in;
      amp_ff      <= amp_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      quo_ff      <= quo_in;
      rsp_chan_ff <= rsp_chan_in;
      rsp_amp_ff  <= rsp_amp_in;
      rsp_filt_ff <= rsp_filt_in;
   end

   assign stat.sat      = sat_ff;
   assign rsp_channel   = rsp_chan_ff;
   assign rsp_amplitude = rsp_amp_ff;
   assign rsp_filtered  = rsp_filt_ff;

endmodule

// ----- src/tone_amplitude_averager_top.sv -----
`timescale 1ns / 1ps
// Samples: one item per cycle during a burst; items 1 to 19 cause no result.
// After the 20th item: the divide and square steps, the radicand step, up to 16
// square-root steps, the amplitude and window steps, 16+log2(TAPS) divider steps,
// then the result register, loaded once any earlier result has been taken.
// Reset (synchronous, active high) clears burst sums, window sums, positions
// and entry valid bits at once, and sets the divisor to 1.

module tone_amplitude_averager_top #(
   parameter int TAPS     = taa_pkg::TAPS_DEFAULT,
   parameter int CHANNELS = taa_pkg::CHANNELS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // sample
   input  logic [2:0]  req_tuser,    // channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // amplitude, filtered
   output logic [2:0]  rsp_tuser,    // channel_out
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data   // output_divisor
);

   taa_pkg::cmd_type  cmd;
   taa_pkg::stat_type stat;
   logic [taa_pkg::AMP_W-1:0] amplitude;
   logic [taa_pkg::AMP_W-1:0] filtered;

   taa_ctrl #(
      .TAPS (TAPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   taa_datapath #(
      .TAPS     (TAPS),
      .CHANNELS (CHANNELS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_sample    (req_tdata),
      .req_channel   (req_tuser),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_channel   (rsp_tuser),
      .rsp_amplitude (amplitude),
      .rsp_filtered  (filtered)
   );

   assign rsp_tdata = {filtered, amplitude};

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == taa_pkg::OP_LOAD) |-> (!rsp_tvalid || rsp_tready))
      else $error("result loaded over an untaken item");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == taa_pkg::OP_LOAD) |=> rsp_tvalid)
      else $error("loaded result not presented");

   a_busy_no_take: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |->
         (cmd.op == taa_pkg::OP_ACCUM || cmd.op == taa_pkg::OP_NONE))
      else $error("item taken while burst finishing");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

   localparam int TAPS           = taa_pkg::TAPS_DEFAULT;
   localparam int CHANNELS       = taa_pkg::CHANNELS_DEFAULT;
   localparam int BURST          = taa_pkg::BURST_LENGTH;
   localparam int DISCARD        = taa_pkg::DISCARD_COUNT;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 70;
   localparam int HOLD_CYCLES    = 1500;
   localparam int HOLD_AFTER     = 3;
   localparam int PHASES         = 6;
   localparam int PHASE_BURSTS   = 8;

   localparam int TONE_COS [10] = '{100, 81, 31, -31, -81, -100, -81, -31, 31, 81};
   localparam int TONE_SIN [10] = '{0, 59, 95, 95, 59, 0, -59, -95, -95, -59};

   typedef struct packed {
      logic [2:0]  chan;
      logic [15:0] amp;
      logic [15:0] filt;
   } tone_result_type;

   typedef struct packed {
      logic [15:0]     sample;
      logic [2:0]      chan;
      bit              pinned;
      tone_result_type want;
   } script_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // sample
   logic [2:0]  req_tuser;    // channel
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // amplitude, filtered
   logic [2:0]  rsp_tuser;    // channel_out
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;  // output_divisor

   tone_amplitude_averager_top #(
      .TAPS     (TAPS),
      .CHANNELS (CHANNELS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // predictor state
   int          burst_pos;
   int          cos_acc;
   int          sin_acc;
   logic [15:0] win_mem   [CHANNELS*TAPS];
   logic [19:0] win_total [CHANNELS];
   int          win_slot  [CHANNELS];
   logic [15:0] divisor;

   tone_result_type awaited_bursts [$];
   int              error_count;
   int              results_seen;
   bit              tx_calm;

   // full-scale samples 11..20 cancel over the table; channel 7 has no window
   script_row_type opening [25] = '{
      '{16'hFFFF, 3'd0, 1'b0, '0},
      '{16'h0000, 3'd1, 1'b0, '0},
      '{16'h5555, 3'd2, 1'b0, '0},
      '{16'hAAAA, 3'd3, 1'b0, '0},
      '{16'hFFFF, 3'd4, 1'b0, '0},
      '{16'h0000, 3'd5, 1'b0, '0},
      '{16'h00FF, 3'd6, 1'b0, '0},
      '{16'hFF00, 3'd7, 1'b0, '0},
      '{16'h8000, 3'd0, 1'b0, '0},
      '{16'h0001, 3'd5, 1'b0, '0},
      '{16'hFFFF, 3'd3, 1'b0, '0},
      '{16'hFFFF, 3'd6, 1'b0, '0},
      '{16'hFFFF, 3'd1, 1'b0, '0},
      '{16'hFFFF, 3'd0, 1'b0, '0},
      '{16'hFFFF, 3'd5, 1'b0, '0},
      '{16'hFFFF, 3'd2, 1'b0, '0},
      '{16'hFFFF, 3'd4, 1'b0, '0},
      '{16'hFFFF, 3'd7, 1'b0, '0},
      '{16'hFFFF, 3'd6, 1'b0, '0},
      '{16'hFFFF, 3'd7, 1'b1, '{3'd7, 16'd0, 16'd0}},
      '{16'hFFFF, 3'd0, 1'b0, '0},
      '{16'h0000, 3'd1, 1'b0, '0},
      '{16'h1234, 3'd2, 1'b0, '0},
      '{16'hFFFF, 3'd3, 1'b0, '0},
      '{16'h0000, 3'd4, 1'b0, '0}
   };

   function automatic logic [15:0] floor_root16(longint unsigned v);
      logic [31:0] r;
      logic [31:0] t;
      if (v >= 64'h1_0000_0000) return 16'hFFFF;
      r = '0;
      for (int i = 15; i >= 0; i--) begin
         t = r | (32'h1 << i);
         if (64'(t) * 64'(t) <= v) r = t;
      end
      return r[15:0];
   endfunction

   function automatic void clear_tone_model();
      burst_pos = 0;
      cos_acc   = 0;
      sin_acc   = 0;
      divisor   = 16'd1;
      foreach (win_mem[i]) win_mem[i] = '0;
      foreach (win_total[i]) begin
         win_total[i] = '0;
         win_slot[i]  = 0;
      end
   endfunction

   function automatic bit tone_burst_step(input logic [15:0] s, input logic [2:0] c,
                                          output tone_result_type res);
      int              sv;
      int              e;
      int              slot;
      longint          an;
      longint          bn;
      longint unsigned pw;
      logic [15:0]     amp;
      logic [31:0]     quo;
      logic [15:0]     div;
      sv  = s;
      res = '0;
      if (burst_pos >= BURST) burst_pos = 0;
      burst_pos++;
      if (burst_pos > DISCARD) begin
         e = burst_pos % 10;
         cos_acc = cos_acc + 5 * sv * TONE_COS[e];
         sin_acc = sin_acc + 5 * sv * TONE_SIN[e];
      end
      if (burst_pos < BURST) return 1'b0;
      an  = cos_acc / 100;
      bn  = sin_acc / 100;
      pw  = an * an + bn * bn;
      amp = floor_root16(pw * 25);
      burst_pos = 0;
      cos_acc   = 0;
      sin_acc   = 0;
      res.chan  = c;
      res.amp   = amp;
      if (c < CHANNELS) begin
         slot = win_slot[c];
         div  = (divisor == 16'd0) ? 16'd1 : divisor;
         win_total[c] = win_total[c] - win_mem[c*TAPS + slot];
         win_mem[c*TAPS + slot] = amp;
         win_total[c] = win_total[c] + amp;
         win_slot[c]  = (slot == TAPS - 1) ? 0 : slot + 1;
         quo = 32'(win_total[c]) / TAPS / 32'(div);
         res.filt = quo[15:0];
      end
      return 1'b1;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_item(input logic [15:0] s, input logic [2:0] c,
                            input bit pinned, input tone_result_type pin);
      int              gap;
      tone_result_type res;
      gap = tx_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tuser  <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (tone_burst_step(s, c, res)) awaited_bursts.push_back(pinned ? pin : res);
   endtask

   task automatic run_bursts(input int count);
      logic [2:0]  base;
      logic [2:0]  c;
      logic [15:0] s;
      logic [15:0] mask;
      int          mode;
      bit          hopping;
      for (int b = 0; b < count; b++) begin
         base    = ($urandom_range(0, 99) < 80) ? 3'($urandom_range(0, CHANNELS - 1))
                                                : 3'($urandom_range(CHANNELS, 7));
         mode    = $urandom_range(0, 9);
         mask    = 16'((32'h1 << $urandom_range(1, 16)) - 1);
         hopping = ($urandom_range(0, 9) == 0);
         tx_calm = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < BURST; k++) begin
            if (mode < 6) s = 16'($urandom) & mask;
            else if (mode < 8) s = 16'($urandom);
            else s = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            c = (hopping && k < BURST - 1) ? 3'($urandom_range(0, 7)) : base;
            send_item(s, c, 1'b0, '0);
         end
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (awaited_bursts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_divisor(input logic [15:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      divisor = v;
      csr_wr_en <= 1'b0;
   endtask

   task automatic check_result();
      tone_result_type got;
      tone_result_type want;
      got.chan = rsp_tuser;
      got.amp  = rsp_tdata[15:0];
      got.filt = rsp_tdata[31:16];
      results_seen++;
      if (awaited_bursts.size() == 0) begin
         $error("unexpected item: channel_out %0d amplitude %0d filtered %0d",
                got.chan, got.amp, got.filt);
         error_count++;
      end else begin
         want = awaited_bursts.pop_front();
         if (got.chan !== want.chan) begin
            $error("channel_out: expected %0d, actual %0d", want.chan, got.chan);
            error_count++;
         end
         if (got.amp !== want.amp) begin
            $error("amplitude: expected %0d, actual %0d", want.amp, got.amp);
            error_count++;
         end
         if (got.filt !== want.filt) begin
            $error("filtered: expected %0d, actual %0d", want.filt, got.filt);
            error_count++;
         end
      end
   endtask

   // result side: random stalls, calm stretches, one long hold-off
   initial begin
      int  stall_left;
      int  calm_left;
      int  hold_left;
      int  r;
      bit  hold_done;
      stall_left = 0;
      calm_left  = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_result();
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            r = $urandom_range(0, 99);
            if (r < 3) calm_left = $urandom_range(100, 400);
            else if (r < 30) stall_left = pick_gap();
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      logic [15:0] plan [PHASES];
      logic [15:0] v;
      plan         = '{16'd0, 16'hFFFF, 16'd2, 16'd1, 16'd0, 16'd7};
      error_count  = 0;
      results_seen = 0;
      tx_calm      = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      clear_tone_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening[i])
         send_item(opening[i].sample, opening[i].chan, opening[i].pinned, opening[i].want);

      for (int p = 0; p < PHASES; p++) begin
         settle();
         v = (p == 4) ? 16'($urandom_range(3, 65534)) : plan[p];
         write_divisor(v);
         run_bursts(PHASE_BURSTS);
      end

      settle();
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
